>>> src/awsl_pkg.sv
package awsl_pkg;

  localparam int NUM_CHANNELS      = 8;
  localparam int CH_IDX_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SAMPLES_PER_BLOCK = 4;
  localparam int SPB_SHIFT         = $clog2(SAMPLES_PER_BLOCK);

  localparam int CHAN_W   = 3;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 24;
  localparam int SAMPLE_W = 16;
  localparam int LIMIT_W  = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LINK_GAP_LIMIT_RST = LIMIT_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CYCLE_OFFSET   = 8'd0,
    CFG_LINK_GAP_LIMIT = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] c;
    logic [SAMPLE_W-1:0] d;
  } samples_t;

  // input transaction as captured at the port
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic              packet_start;
    logic [TIME_W-1:0] block_time;
    samples_t          samples;
  } blk_t;

  // after per-channel state lookup
  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic               start;
    logic               eval_link;
    logic [TIME_W-1:0]  block_time;
    logic [TIME_W-1:0]  old_time;
    logic [COUNT_W-1:0] old_count;
    samples_t           samples;
  } lookup_t;

  // after time difference
  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic               start;
    logic               eval_link;
    logic [TIME_W:0]    diff;
    logic [COUNT_W-1:0] old_count;
    samples_t           samples;
  } diff_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic                wave_start;
    logic                linked_prev;
    logic [SAMPLE_W-1:0] fill_zeros;
    samples_t            samples;
  } result_t;

endpackage

>>> src/adc_waveform_segment_link.sv
// Waveform segment linker for a multi-channel digitizer stream.
// Input channel: one data block per transaction (channel, packet start mark,
// block timestamp, four samples), taken when in_valid is high and in_stall low.
// Result channel: one result per block, in order, offered on out_valid and
// taken when out_stall is low; samples and channel pass through unchanged.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
// the timestamp wrap period, index 1 the link gap limit. Write only while idle.
// A taken block passes the input, lookup, difference and result registers.
// Throughput: one block per cycle while out_stall is low; per-channel state
// lives in flip-flops and is read and updated in the lookup stage, so blocks on
// the same channel may follow each other back to back.
// Stall: the four pipeline registers hold while out_stall is high, except that
// an empty slot always refills; in_stall rises only once every stage is full.
// Reset: pipeline empties, every channel starts with no waveform, wrap period
// goes to 0 and the link gap limit to 1000. No clearing pass is needed.
module adc_waveform_segment_link (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [awsl_pkg::CHAN_W-1:0]     in_channel,
  input  logic                            in_packet_start,
  input  logic [awsl_pkg::TIME_W-1:0]     in_block_time,
  input  logic [awsl_pkg::SAMPLE_W-1:0]   in_sample_a,
  input  logic [awsl_pkg::SAMPLE_W-1:0]   in_sample_b,
  input  logic [awsl_pkg::SAMPLE_W-1:0]   in_sample_c,
  input  logic [awsl_pkg::SAMPLE_W-1:0]   in_sample_d,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [awsl_pkg::CHAN_W-1:0]     out_channel,
  output logic                            out_wave_start,
  output logic                            out_linked_prev,
  output logic [awsl_pkg::SAMPLE_W-1:0]   out_fill_zeros,
  output logic [awsl_pkg::SAMPLE_W-1:0]   out_a,
  output logic [awsl_pkg::SAMPLE_W-1:0]   out_b,
  output logic [awsl_pkg::SAMPLE_W-1:0]   out_c,
  output logic [awsl_pkg::SAMPLE_W-1:0]   out_d,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [awsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [awsl_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [awsl_pkg::TIME_W-1:0]  cycle_offset_r;
  logic [awsl_pkg::LIMIT_W-1:0] link_gap_limit_r;

  awsl_pkg::blk_t    blk_r;
  awsl_pkg::lookup_t lookup_r;
  awsl_pkg::result_t result_r;

  logic v0_r, v1_r, v2_r, v3_r;
  logic en0, en1, en2, en3;

  // a stage loads when it is empty or its contents move on
  assign en3 = !v3_r || !out_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_stall  = !en0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_valid) begin
      blk_r.channel      <= in_channel;
      blk_r.packet_start <= in_packet_start;
      blk_r.block_time   <= in_block_time;
      blk_r.samples.a    <= in_sample_a;
      blk_r.samples.b    <= in_sample_b;
      blk_r.samples.c    <= in_sample_c;
      blk_r.samples.d    <= in_sample_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_offset_r   <= '0;
      link_gap_limit_r <= awsl_pkg::LINK_GAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        awsl_pkg::CFG_CYCLE_OFFSET: begin
          cycle_offset_r <= cfg_data[awsl_pkg::TIME_W-1:0];
        end
        awsl_pkg::CFG_LINK_GAP_LIMIT: begin
          link_gap_limit_r <= cfg_data[awsl_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  awsl_chan_state u_chan_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .blk_valid(v0_r),
    .blk      (blk_r),
    .load     (en1),
    .lookup_r (lookup_r)
  );

  awsl_gap_calc u_gap_calc (
    .clk           (clk),
    .load_diff     (en2),
    .load_res      (en3),
    .lookup_r      (lookup_r),
    .cycle_offset  (cycle_offset_r),
    .link_gap_limit(link_gap_limit_r),
    .result_r      (result_r)
  );

  assign out_valid       = v3_r;
  assign out_channel     = result_r.channel;
  assign out_wave_start  = result_r.wave_start;
  assign out_linked_prev = result_r.linked_prev;
  assign out_fill_zeros  = result_r.fill_zeros;
  assign out_a           = result_r.samples.a;
  assign out_b           = result_r.samples.b;
  assign out_c           = result_r.samples.c;
  assign out_d           = result_r.samples.d;

endmodule

>>> src/awsl_chan_state.sv
module awsl_chan_state (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            blk_valid,
  input  awsl_pkg::blk_t  blk,
  input  logic            load,
  output awsl_pkg::lookup_t lookup_r
);

  logic [awsl_pkg::TIME_W-1:0]  start_time_r [awsl_pkg::NUM_CHANNELS];
  logic [awsl_pkg::COUNT_W-1:0] block_count_r [awsl_pkg::NUM_CHANNELS];
  logic [awsl_pkg::NUM_CHANNELS-1:0] seen_r;

  logic [awsl_pkg::CH_IDX_W-1:0] idx;
  logic [awsl_pkg::TIME_W-1:0]   cur_time;
  logic [awsl_pkg::COUNT_W-1:0]  cur_count;
  logic                          cur_seen;
  logic [awsl_pkg::TIME_W-1:0]   expect_time;
  logic                          start;
  logic [awsl_pkg::COUNT_W-1:0]  count_nxt;
  logic                          upd;
  awsl_pkg::lookup_t             lookup_nxt;

  assign idx       = awsl_pkg::CH_IDX_W'(blk.channel % awsl_pkg::NUM_CHANNELS);
  assign cur_time  = start_time_r[idx];
  assign cur_count = block_count_r[idx];
  assign cur_seen  = seen_r[idx];
  assign expect_time = cur_time + awsl_pkg::TIME_W'(cur_count);
  assign start = !cur_seen || blk.packet_start || (expect_time != blk.block_time);
  assign upd   = load && blk_valid;

  always_comb begin
    if (start) begin
      count_nxt = awsl_pkg::COUNT_W'(1);
    end else if (cur_count < awsl_pkg::COUNT_MAX) begin
      count_nxt = cur_count + awsl_pkg::COUNT_W'(1);
    end else begin
      count_nxt = cur_count;
    end
  end

  always_comb begin
    lookup_nxt.channel    = blk.channel;
    lookup_nxt.start      = start;
    lookup_nxt.eval_link  = start && cur_seen;
    lookup_nxt.block_time = blk.block_time;
    lookup_nxt.old_time   = cur_time;
    lookup_nxt.old_count  = cur_count;
    lookup_nxt.samples    = blk.samples;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (upd) begin
      seen_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      block_count_r[idx] <= count_nxt;
      if (start) begin
        start_time_r[idx] <= blk.block_time;
      end
    end
    if (load) begin
      lookup_r <= lookup_nxt;
    end
  end

endmodule

>>> src/awsl_gap_calc.sv
module awsl_gap_calc (
  input  logic                          clk,
  input  logic                          load_diff,
  input  logic                          load_res,
  input  awsl_pkg::lookup_t             lookup_r,
  input  logic [awsl_pkg::TIME_W-1:0]   cycle_offset,
  input  logic [awsl_pkg::LIMIT_W-1:0]  link_gap_limit,
  output awsl_pkg::result_t             result_r
);

  localparam int GAP_W = awsl_pkg::TIME_W + 1 + awsl_pkg::SPB_SHIFT;

  awsl_pkg::diff_t            diff_r;
  awsl_pkg::diff_t            diff_nxt;
  awsl_pkg::result_t          result_nxt;
  logic [awsl_pkg::TIME_W:0]   fwd_diff;
  logic [awsl_pkg::TIME_W:0]   wrap_diff;
  logic                        t_larger;
  logic [awsl_pkg::TIME_W+1:0] blk_gap;
  logic [GAP_W-1:0]            gap;
  logic                        linked;

  // stage 1: time difference, wrapping through the cycle offset
  assign fwd_diff  = {1'b0, lookup_r.block_time} - {1'b0, lookup_r.old_time};
  assign wrap_diff = {1'b0, lookup_r.old_time} + {1'b0, cycle_offset}
                     - {1'b0, lookup_r.block_time};
  assign t_larger  = lookup_r.block_time > lookup_r.old_time;

  always_comb begin
    diff_nxt.channel   = lookup_r.channel;
    diff_nxt.start     = lookup_r.start;
    diff_nxt.eval_link = lookup_r.eval_link;
    diff_nxt.diff      = t_larger ? fwd_diff : wrap_diff;
    diff_nxt.old_count = lookup_r.old_count;
    diff_nxt.samples   = lookup_r.samples;
  end

  // stage 2: gap in samples, negative gap never links
  assign blk_gap = {1'b0, diff_r.diff}
                   - {{(awsl_pkg::TIME_W + 2 - awsl_pkg::COUNT_W){1'b0}}, diff_r.old_count};
  assign gap     = {blk_gap[awsl_pkg::TIME_W:0], {awsl_pkg::SPB_SHIFT{1'b0}}};
  assign linked  = diff_r.eval_link && !blk_gap[awsl_pkg::TIME_W+1]
                   && (gap < GAP_W'(link_gap_limit));

  always_comb begin
    result_nxt.channel     = diff_r.channel;
    result_nxt.wave_start  = diff_r.start;
    result_nxt.linked_prev = linked;
    result_nxt.fill_zeros  = linked ? gap[awsl_pkg::SAMPLE_W-1:0] : '0;
    result_nxt.samples     = diff_r.samples;
  end

  always_ff @(posedge clk) begin
    if (load_diff) begin
      diff_r <= diff_nxt;
    end
    if (load_res) begin
      result_r <= result_nxt;
    end
  end

endmodule
